/* design/fatp_pkg.sv */
`default_nettype none

package fatp_pkg;

	// Width and ceiling of the hit and access counters
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Requests from the sequencer to the replacement tree engine
	typedef struct packed {
		logic walk;   // walk the tree from the root and return a victim line
		logic touch;  // point the path of the given line away from it
	} plru_cmd_t;

	// Status of the replacement tree engine
	typedef struct packed {
		logic ready;  // clearing pass over, engine idle
		logic done;   // one-cycle pulse: walk or touch finished
	} plru_sts_t;

endpackage

`default_nettype wire

/* design/fatp_if.sv */
`default_nettype none

// Request channel: one byte address per transaction
interface fatp_req_if #(
	parameter int ADDR_BITS = 32
) ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

// Response channel: one result per request
interface fatp_rsp_if #(
	parameter int LINE_W = 9
) ();
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [LINE_W-1:0]          line_used;
	logic [fatp_pkg::CNT_W-1:0] hit_total;
	logic [fatp_pkg::CNT_W-1:0] access_total;

	modport source (output valid, output hit, output line_used, output hit_total,
		output access_total, input ready);
	modport sink (input valid, input hit, input line_used, input hit_total,
		input access_total, output ready);
endinterface

`default_nettype wire

/* design/fully_assoc_tree_plru_cache_top.sv */
// Fully associative cache model with tree pseudo-LRU replacement.
//
// req carries one byte address per transaction; rsp returns one result per
// request: hit flag, line used, and saturating hit and access totals.
// Only one request is in flight: req.ready is high only while the block is
// idle. The result appears on rsp in the cycle that req.ready returns. The
// tag scan reads one entry per cycle from the tag RAM; the line address is
// a registered shift, and a miss walks the tree RAM from the root down before
// updating the path from the line up.
// After reset, a clearing pass writes every tag entry invalid and every tree
// bit zero; req.ready rises once it ends and the tree engine is ready.
// The result sits in an output register; the next request is accepted while
// it waits. If rsp.ready is low when the next result is ready, the block
// holds that result internally and waits before accepting more.
`default_nettype none

module fully_assoc_tree_plru_cache_top #(
	parameter int LINES      = 512,
	parameter int LINE_BYTES = 32,
	parameter int ADDR_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	fatp_req_if.sink          req,
	fatp_rsp_if.source        rsp
);

	localparam int LINE_W = $clog2(LINES);
	localparam int LB_W   = $clog2(LINE_BYTES + 1);
	localparam int TAG_W  = (ADDR_BITS >= LB_W) ? (ADDR_BITS - LB_W + 1) : 1;
	localparam int CNT_W  = fatp_pkg::CNT_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_MISS  = 9'b000010000,
		S_WALK  = 9'b000100000,
		S_UPD   = 9'b001000000,
		S_TOUCH = 9'b010000000,
		S_FIN   = 9'b100000000
	} top_state_t;

	top_state_t          state_q;
	logic [LINE_W-1:0]   clr_q;
	logic                clr_done_q;
	logic [TAG_W-1:0]    tag_q;
	logic [LINE_W-1:0]   scan_k_q;
	logic [LINE_W-1:0]   scan_k_s1;
	logic                chk_s1;
	logic [LINE_W-1:0]   line_q;
	logic                hit_q;
	logic [CNT_W-1:0]    hitc_q;
	logic [CNT_W-1:0]    accc_q;
	logic                ovalid_q;
	logic                out_hit_q;
	logic [LINE_W-1:0]   out_line_q;
	logic [CNT_W-1:0]    out_hitc_q;
	logic [CNT_W-1:0]    out_accc_q;

	logic                div_done;
	logic [ADDR_BITS-1:0] quot;
	logic                tag_we;
	logic [LINE_W-1:0]   tag_waddr;
	logic [TAG_W:0]      tag_wdata;
	logic [TAG_W:0]      tag_rdata;
	logic                match;
	logic                last;
	logic                load;
	logic [CNT_W-1:0]    hitc_nx;
	logic [CNT_W-1:0]    accc_nx;
	fatp_pkg::plru_cmd_t plru_cmd;
	fatp_pkg::plru_sts_t plru_sts;
	logic [LINE_W-1:0]   victim;

	// Line address from the byte address
	fatp_div #(
		.ADDR_BITS  (ADDR_BITS),
		.LINE_BYTES (LINE_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req.valid && req.ready),
		.dividend (req.address),
		.done     (div_done),
		.quotient (quot)
	);

	// Tag RAM entry: {valid, tag}
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = clr_q;
		tag_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				tag_we = !clr_done_q;
			end
			S_UPD: begin
				tag_we    = !hit_q;
				tag_waddr = line_q;
				tag_wdata = {1'b1, tag_q};
			end
			default: begin
				tag_we = 1'b0;
			end
		endcase
	end

	fatp_ram #(
		.WIDTH (TAG_W + 1),
		.DEPTH (LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (scan_k_q),
		.rdata (tag_rdata)
	);

	// Replacement tree
	assign plru_cmd.walk  = (state_q == S_MISS);
	assign plru_cmd.touch = (state_q == S_UPD);

	fatp_plru #(
		.LINES (LINES)
	) u_plru (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (plru_cmd),
		.line   (line_q),
		.sts    (plru_sts),
		.victim (victim)
	);

	// Scan compare in the cycle after the read address is issued
	assign match = (state_q == S_SCAN) && chk_s1 && tag_rdata[TAG_W]
		&& (tag_rdata[TAG_W-1:0] == tag_q);
	assign last  = chk_s1 && (scan_k_s1 == LINE_W'(LINES - 1));

	// Saturating totals including this transaction
	assign hitc_nx = (hit_q && (hitc_q != fatp_pkg::CNT_MAX)) ? hitc_q + CNT_W'(1) : hitc_q;
	assign accc_nx = (accc_q != fatp_pkg::CNT_MAX) ? accc_q + CNT_W'(1) : accc_q;
	assign load    = (state_q == S_FIN) && (!ovalid_q || rsp.ready);

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			scan_k_q   <= '0;
			chk_s1     <= 1'b0;
			hit_q      <= 1'b0;
			hitc_q     <= '0;
			accc_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			chk_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_CLEAR: begin
					if (!clr_done_q) begin
						clr_q <= clr_q + LINE_W'(1);
						if (clr_q == LINE_W'(LINES - 1)) begin
							clr_done_q <= 1'b1;
						end
					end else if (plru_sts.ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					scan_k_q <= '0;
					if (div_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_k_q != LINE_W'(LINES - 1)) begin
						scan_k_q <= scan_k_q + LINE_W'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_UPD;
					end else if (last) begin
						hit_q   <= 1'b0;
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (plru_sts.done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_TOUCH;
				end
				S_TOUCH: begin
					if (plru_sts.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load) begin
						hitc_q  <= hitc_nx;
						accc_q  <= accc_nx;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Hold the result until the receiver takes it
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_done) begin
			tag_q <= quot[TAG_W-1:0];
		end
		scan_k_s1 <= scan_k_q;
		if (match) begin
			line_q <= scan_k_s1;
		end else if (state_q == S_WALK && plru_sts.done) begin
			line_q <= victim;
		end
		if (load) begin
			out_hit_q  <= hit_q;
			out_line_q <= line_q;
			out_hitc_q <= hitc_nx;
			out_accc_q <= accc_nx;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = ovalid_q;
	assign rsp.hit          = out_hit_q;
	assign rsp.line_used    = out_line_q;
	assign rsp.hit_total    = out_hitc_q;
	assign rsp.access_total = out_accc_q;

endmodule

`default_nettype wire

/* design/fatp_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module fatp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read on the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/fatp_div.sv */
`default_nettype none

// Line address from a byte address: the line size is a power of two, so the
// division is a registered right shift, ready in the cycle after start
module fatp_div #(
	parameter int ADDR_BITS  = 32,
	parameter int LINE_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADDR_BITS-1:0] dividend,
	output logic                 done,
	output logic [ADDR_BITS-1:0] quotient
);

	localparam int SHIFT = $clog2(LINE_BYTES);

	logic                 done_q;
	logic [ADDR_BITS-1:0] quot_q;

	// Only a power-of-two line size reduces to a shift
	if (LINE_BYTES != (1 << SHIFT)) begin : g_line_bytes_check
		$error("LINE_BYTES must be a power of two");
	end

	// Pulse done in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// Drop the offset bits
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend >> SHIFT;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

/* design/fatp_plru.sv */
`default_nettype none

// Tree pseudo-LRU engine: tree bits in a RAM, walked or updated one node a step
module fatp_plru #(
	parameter int LINES = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fatp_pkg::plru_cmd_t       cmd,
	input  logic [$clog2(LINES)-1:0]  line,
	output fatp_pkg::plru_sts_t       sts,
	output logic [$clog2(LINES)-1:0]  victim
);

	localparam int LINE_W = $clog2(LINES);
	localparam int NODES  = LINES - 1;
	localparam int NODE_W = $clog2(2 * LINES - 1);
	localparam int TAW    = (NODES > 1) ? $clog2(NODES) : 1;

	typedef enum logic [4:0] {
		P_CLR  = 5'b00001,
		P_IDLE = 5'b00010,
		P_WRD  = 5'b00100,
		P_WNX  = 5'b01000,
		P_TCH  = 5'b10000
	} plru_state_t;

	plru_state_t       state_q;
	logic [NODE_W-1:0] node_q;
	logic [TAW-1:0]    clr_q;
	logic              done_q;
	logic [LINE_W-1:0] victim_q;

	logic              we;
	logic [TAW-1:0]    waddr;
	logic              wdata;
	logic              rdata;
	logic [NODE_W-1:0] parent;
	logic [NODE_W:0]   child;
	logic              is_leaf;

	assign parent  = (node_q - NODE_W'(1)) >> 1;
	assign child   = {node_q, 1'b0} + (NODE_W + 1)'(1) + (NODE_W + 1)'(rdata);
	assign is_leaf = (node_q >= NODE_W'(NODES));

	// Tree RAM write port: clearing sweep or path update
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = 1'b0;
		case (state_q)
			P_CLR: begin
				we = 1'b1;
			end
			P_TCH: begin
				we    = (node_q != '0);
				waddr = parent[TAW-1:0];
				wdata = node_q[0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	fatp_ram #(
		.WIDTH (1),
		.DEPTH (NODES)
	) u_tree_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (node_q[TAW-1:0]),
		.rdata (rdata)
	);

	// Walk, touch and clear sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= P_CLR;
			node_q   <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
			victim_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_CLR: begin
					clr_q <= clr_q + TAW'(1);
					if (clr_q == TAW'(NODES - 1)) begin
						state_q <= P_IDLE;
					end
				end
				P_IDLE: begin
					if (cmd.walk) begin
						node_q  <= '0;
						state_q <= P_WRD;
					end else if (cmd.touch) begin
						node_q  <= NODE_W'(line) + NODE_W'(NODES);
						state_q <= P_TCH;
					end
				end
				P_WRD: begin
					if (is_leaf) begin
						victim_q <= LINE_W'(node_q - NODE_W'(NODES));
						done_q   <= 1'b1;
						state_q  <= P_IDLE;
					end else begin
						state_q <= P_WNX;
					end
				end
				P_WNX: begin
					node_q  <= child[NODE_W-1:0];
					state_q <= P_WRD;
				end
				P_TCH: begin
					if (node_q == '0) begin
						done_q  <= 1'b1;
						state_q <= P_IDLE;
					end else begin
						node_q <= parent;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	assign sts.ready = (state_q == P_IDLE);
	assign sts.done  = done_q;
	assign victim    = victim_q;

endmodule

`default_nettype wire

/* design/fatp_checker.sv */
`default_nettype none

// Port-level checks on the cache block
module fatp_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  logic                       rsp_hit,
	input  logic [fatp_pkg::CNT_W-1:0] hit_total,
	input  logic [fatp_pkg::CNT_W-1:0] access_total
);

	// A pending result stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// One request at a time: ready drops after each accepted transaction
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request accepted while one is in flight");

	// A hit is counted in the total it carries
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> hit_total != '0)
		else $error("hit reported with zero hit total");

	// Hits never exceed accesses, and every result counts its own access
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (hit_total <= access_total) && (access_total != '0))
		else $error("hit and access totals inconsistent");

endmodule

bind fully_assoc_tree_plru_cache_top fatp_checker u_fatp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_hit      (rsp.hit),
	.hit_total    (rsp.hit_total),
	.access_total (rsp.access_total)
);

`default_nettype wire
